// ----- design/r2q_pkg.sv -----
// Shared constants for the rotation matrix to quaternion unit.
`default_nettype none
package r2q_pkg;
  localparam logic [1:0] FORM_X = 2'd0;
  localparam logic [1:0] FORM_Y = 2'd1;
  localparam logic [1:0] FORM_Z = 2'd2;
  localparam logic [1:0] FORM_W = 2'd3;
endpackage
`default_nettype wire

// ----- design/r2q_front.sv -----
// Front end: takes a matrix, picks the form, builds t and the unscaled components.
`default_nettype none
module r2q_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic signed [DATA_WIDTH-1:0] m00,
  input  logic signed [DATA_WIDTH-1:0] m01,
  input  logic signed [DATA_WIDTH-1:0] m02,
  input  logic signed [DATA_WIDTH-1:0] m10,
  input  logic signed [DATA_WIDTH-1:0] m11,
  input  logic signed [DATA_WIDTH-1:0] m12,
  input  logic signed [DATA_WIDTH-1:0] m20,
  input  logic signed [DATA_WIDTH-1:0] m21,
  input  logic signed [DATA_WIDTH-1:0] m22,
  output logic                        item_vld,
  output logic [2+5*(DATA_WIDTH+2)-1:0] item_data
);
  import r2q_pkg::*;

  localparam int CW = DATA_WIDTH + 2;
  localparam int F  = DATA_WIDTH - 2;

  logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, one;
  logic signed [CW-1:0] t, c0, c1, c2, c3, dif;
  logic [1:0] form;

  assign e00 = CW'(m00);
  assign e01 = CW'(m01);
  assign e02 = CW'(m02);
  assign e10 = CW'(m10);
  assign e11 = CW'(m11);
  assign e12 = CW'(m12);
  assign e20 = CW'(m20);
  assign e21 = CW'(m21);
  assign e22 = CW'(m22);
  assign one = CW'(1) <<< F;
  assign dif = e00 - e11;

  always_comb begin
    if (m22[DATA_WIDTH-1]) begin
      if (e00 > e11) begin
        form = FORM_X;
        t  = one + dif - e22;
        c0 = e21 - e12; c1 = t; c2 = e01 + e10; c3 = e20 + e02;
      end else begin
        form = FORM_Y;
        t  = one - dif - e22;
        c0 = e02 - e20; c1 = e01 + e10; c2 = t; c3 = e12 + e21;
      end
    end else if ((e00 + e11) < 0) begin
      form = FORM_Z;
      t  = one - e00 - (e11 - e22);
      c0 = e10 - e01; c1 = e02 + e20; c2 = e12 + e21; c3 = t;
    end else begin
      form = FORM_W;
      t  = one + e00 + e11 + e22;
      c0 = t; c1 = e21 - e12; c2 = e02 - e20; c3 = e10 - e01;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else begin
      item_vld <= take;
    end
    if (take) begin
      item_data <= {form, t, c0, c1, c2, c3};
    end
  end
endmodule
`default_nettype wire

// ----- design/r2q_queue.sv -----
// Two-entry queue between the front end and the scaling pipeline.
`default_nettype none
module r2q_queue #(
  parameter int IW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [IW-1:0] din,
  output logic          full,
  output logic          out_vld,
  output logic [IW-1:0] out_data
);
  logic [IW-1:0] mem [0:1];
  logic          wp, rp;
  logic [1:0]    count;
  logic          pop;

  // back end never stalls, so drain whenever something is held
  assign pop  = (count != 2'd0);
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
    if (pop) begin
      out_data <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= 1'b0;
      rp      <= 1'b0;
      count   <= 2'd0;
      out_vld <= 1'b0;
    end else begin
      out_vld <= pop;
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- design/r2q_back.sv -----
// Back end: pipelined square root, then four pipelined dividers with rounding and saturation.
`default_nettype none
module r2q_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic [2+5*(DATA_WIDTH+2)-1:0] in_data,
  output logic                          done,
  output logic signed [DATA_WIDTH-1:0]  quat_w,
  output logic signed [DATA_WIDTH-1:0]  quat_x,
  output logic signed [DATA_WIDTH-1:0]  quat_y,
  output logic signed [DATA_WIDTH-1:0]  quat_z,
  output logic [1:0]                    form_used,
  output logic                          invalid
);
  localparam int W  = DATA_WIDTH;
  localparam int CW = W + 2;
  localparam int F  = W - 2;
  localparam int RW = W + 3;
  localparam int NW = 2 * W + 1;

  // square-root pipeline
  logic                sq_vld  [0:W];
  logic [1:0]          sq_form [0:W];
  logic                sq_inv  [0:W];
  logic [3:0][CW-1:0]  sq_c    [0:W];
  logic [2*W-1:0]      sq_n    [0:W];
  logic [RW-1:0]       sq_rem  [0:W];
  logic [W-1:0]        sq_root [0:W];

  // divider pipeline
  logic                dv_vld  [0:W];
  logic [1:0]          dv_form [0:W];
  logic                dv_inv  [0:W];
  logic [3:0]          dv_neg  [0:W];
  logic [3:0]          dv_ovf  [0:W];
  logic [W:0]          dv_d    [0:W];
  logic [3:0][W:0]     dv_rem  [0:W];
  logic [3:0][W-1:0]   dv_low  [0:W];
  logic [3:0][W-1:0]   dv_q    [0:W];

  logic [CW-1:0] t_in;
  assign t_in = in_data[5*CW-1 -: CW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= in_vld;
    end
    sq_form[0] <= in_data[5*CW+1 -: 2];
    sq_inv[0]  <= t_in[CW-1] || (t_in == '0);
    sq_c[0]    <= in_data[4*CW-1:0];
    sq_n[0]    <= {1'b0, t_in[W:0], {F{1'b0}}};
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
  end

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    logic [RW-1:0] rem_sh, trial;
    logic          ge;
    assign rem_sh = {sq_rem[i][RW-3:0], sq_n[i][2*W-1 -: 2]};
    assign trial  = {1'b0, sq_root[i], 2'b01};
    assign ge     = (rem_sh >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i+1] <= 1'b0;
      end else begin
        sq_vld[i+1] <= sq_vld[i];
      end
      sq_form[i+1] <= sq_form[i];
      sq_inv[i+1]  <= sq_inv[i];
      sq_c[i+1]    <= sq_c[i];
      sq_n[i+1]    <= {sq_n[i][2*W-3:0], 2'b00};
      sq_rem[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
      sq_root[i+1] <= {sq_root[i][W-2:0], ge};
    end
  end

  // setup: numerator = |c|*2^F + s, divisor 2s, overflow when quotient needs more than W bits
  logic [W-1:0]     s;
  logic [W:0]       d;
  logic [NW-1:0]    dlim;
  logic [3:0]       su_neg, su_ovf;
  logic [3:0][W:0]  su_rem;
  logic [3:0][W-1:0] su_low;

  assign s    = sq_root[W];
  assign d    = {s, 1'b0};
  assign dlim = {d, {W{1'b0}}};

  always_comb begin
    logic [CW-1:0] cj, mag;
    logic [NW-1:0] num;
    for (int j = 0; j < 4; j++) begin
      cj        = sq_c[W][j];
      su_neg[j] = cj[CW-1];
      mag       = cj[CW-1] ? (~cj + CW'(1)) : cj;
      num       = {1'b0, mag, {F{1'b0}}} + NW'(s);
      su_ovf[j] = (num >= dlim);
      su_rem[j] = num[NW-1:W];
      su_low[j] = num[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= sq_vld[W];
    end
    dv_form[0] <= sq_form[W];
    dv_inv[0]  <= sq_inv[W];
    dv_neg[0]  <= su_neg;
    dv_ovf[0]  <= su_ovf;
    dv_d[0]    <= d;
    dv_rem[0]  <= su_rem;
    dv_low[0]  <= su_low;
    dv_q[0]    <= '0;
  end

  for (genvar i = 0; i < W; i++) begin : g_div
    logic [3:0][W:0]   rem_n;
    logic [3:0][W-1:0] q_n;
    always_comb begin
      logic [W+1:0] rem_sh;
      for (int j = 0; j < 4; j++) begin
        rem_sh = {dv_rem[i][j], dv_low[i][j][W-1]};
        if (rem_sh >= {1'b0, dv_d[i]}) begin
          rem_n[j] = (W+1)'(rem_sh - {1'b0, dv_d[i]});
          q_n[j]   = {dv_q[i][j][W-2:0], 1'b1};
        end else begin
          rem_n[j] = rem_sh[W:0];
          q_n[j]   = {dv_q[i][j][W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i+1] <= 1'b0;
      end else begin
        dv_vld[i+1] <= dv_vld[i];
      end
      dv_form[i+1] <= dv_form[i];
      dv_inv[i+1]  <= dv_inv[i];
      dv_neg[i+1]  <= dv_neg[i];
      dv_ovf[i+1]  <= dv_ovf[i];
      dv_d[i+1]    <= dv_d[i];
      dv_rem[i+1]  <= rem_n;
      for (int j = 0; j < 4; j++) begin
        dv_low[i+1][j] <= {dv_low[i][j][W-2:0], 1'b0};
      end
      dv_q[i+1]    <= q_n;
    end
  end

  // saturate, apply sign, zero on invalid
  logic [3:0][W-1:0] res;
  always_comb begin
    logic [W-1:0] lim, mag;
    for (int j = 0; j < 4; j++) begin
      lim = dv_neg[W][j] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      mag = (dv_ovf[W][j] || (dv_q[W][j] > lim)) ? lim : dv_q[W][j];
      if (dv_inv[W]) begin
        res[j] = '0;
      end else begin
        res[j] = dv_neg[W][j] ? (~mag + W'(1)) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[W];
    end
    quat_w    <= res[3];
    quat_x    <= res[2];
    quat_y    <= res[1];
    quat_z    <= res[0];
    form_used <= dv_form[W];
    invalid   <= dv_inv[W];
  end
endmodule
`default_nettype wire

// ----- design/rotation_matrix_to_quaternion_unit.sv -----
// Top level: rotation matrix to unit quaternion converter.
// Throughput: one matrix per cycle; the square root and the four dividers
// are pipelined one result bit per stage.
// done strobes for one cycle per result; the receiver cannot stall.
// rst (synchronous) empties the queue and all pipeline valids; busy stays low.
`default_nettype none
module rotation_matrix_to_quaternion_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] m00,
  input  logic signed [DATA_WIDTH-1:0] m01,
  input  logic signed [DATA_WIDTH-1:0] m02,
  input  logic signed [DATA_WIDTH-1:0] m10,
  input  logic signed [DATA_WIDTH-1:0] m11,
  input  logic signed [DATA_WIDTH-1:0] m12,
  input  logic signed [DATA_WIDTH-1:0] m20,
  input  logic signed [DATA_WIDTH-1:0] m21,
  input  logic signed [DATA_WIDTH-1:0] m22,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quat_w,
  output logic signed [DATA_WIDTH-1:0] quat_x,
  output logic signed [DATA_WIDTH-1:0] quat_y,
  output logic signed [DATA_WIDTH-1:0] quat_z,
  output logic [1:0]                   form_used,
  output logic                         invalid
);
  localparam int IW = 2 + 5 * (DATA_WIDTH + 2);

  logic          item_vld, q_vld;
  logic [IW-1:0] item_data, q_data;

  r2q_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst,
    .take     (start && !busy),
    .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
    .item_vld (item_vld),
    .item_data(item_data)
  );

  r2q_queue #(.IW(IW)) u_queue (
    .clk, .rst,
    .push    (item_vld),
    .din     (item_data),
    .full    (busy),
    .out_vld (q_vld),
    .out_data(q_data)
  );

  r2q_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst,
    .in_vld (q_vld),
    .in_data(q_data),
    .done, .quat_w, .quat_x, .quat_y, .quat_z, .form_used, .invalid
  );
endmodule
`default_nettype wire

// ----- design/r2q_checker.sv -----
// Port-level checks for the rotation matrix to quaternion unit, bound to the top level.
`default_nettype none
module r2q_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         busy,
  input logic                         done,
  input logic signed [DATA_WIDTH-1:0] quat_w,
  input logic signed [DATA_WIDTH-1:0] quat_x,
  input logic signed [DATA_WIDTH-1:0] quat_y,
  input logic signed [DATA_WIDTH-1:0] quat_z,
  input logic [1:0]                   form_used,
  input logic                         invalid
);
  import r2q_pkg::*;

  // pipeline drains every cycle, so the queue never fills
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && invalid |-> (quat_w == 0) && (quat_x == 0) && (quat_y == 0) && (quat_z == 0))
    else $error("invalid result not zeroed");

  // the selected component is built from t > 0, so it cannot come out negative
  a_w_form_sign: assert property (@(posedge clk) disable iff (rst)
    done && !invalid && (form_used == FORM_W) |-> !quat_w[DATA_WIDTH-1])
    else $error("w-form gave negative w");

  a_x_form_sign: assert property (@(posedge clk) disable iff (rst)
    done && !invalid && (form_used == FORM_X) |-> !quat_x[DATA_WIDTH-1])
    else $error("x-form gave negative x");

  a_done_pulse_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");
endmodule

bind rotation_matrix_to_quaternion_unit r2q_checker #(.DATA_WIDTH(DATA_WIDTH)) u_r2q_chk (.*);
`default_nettype wire
